### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// Buddy allocator package
// Sizes, codes, state types and slot helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int NUM_ORDERS  = 13;
  localparam int BLOCK_SHIFT = 12;
  localparam int TOP_ORDER   = NUM_ORDERS - 1;
  localparam int ADDR_W      = 40;
  localparam int SLOT_W      = NUM_ORDERS;
  localparam int MAP_SLOTS   = 1 << NUM_ORDERS;
  localparam int I_W         = (TOP_ORDER > 0) ? TOP_ORDER : 1;
  localparam int K_W         = $clog2(NUM_ORDERS);
  localparam int CNT_W       = NUM_ORDERS;
  localparam int WORD_W      = 64;
  localparam int BIT_W       = 6;
  localparam int WORDS       = (MAP_SLOTS > WORD_W) ? MAP_SLOTS / WORD_W : 1;
  localparam int WADDR_W     = (SLOT_W > BIT_W) ? SLOT_W - BIT_W : 1;
  localparam int BLK_W       = ADDR_W - BLOCK_SHIFT;

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_BLOCK  = 2'd1,
    ST_BAD_ORDER = 2'd2,
    ST_BAD_FREE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_AFIND,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_BIT_RD,
    S_BIT_DO,
    S_MERGE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    P_ALLOC_SCAN,
    P_ALLOC_SPLIT,
    P_FREE_UP,
    P_FREE_DOWN,
    P_FREE_MERGE,
    P_FREE_SET
  } phase_t;

  typedef enum logic [1:0] {
    B_TEST,
    B_CLR,
    B_SET
  } bitop_t;

  // bitmap position of block x at order k: orders stacked top order first
  function automatic logic [SLOT_W-1:0] slot_of(input logic [K_W-1:0] k,
                                                 input logic [I_W-1:0] x);
    logic [31:0] base;
    base = (32'd1 << (32'(TOP_ORDER) - 32'(k))) - 32'd1;
    return SLOT_W'(base + 32'(x));
  endfunction

  function automatic logic [WADDR_W-1:0] word_of(input logic [SLOT_W-1:0] s);
    return WADDR_W'(32'(s) >> BIT_W);
  endfunction

  function automatic logic [BIT_W-1:0] bit_of(input logic [SLOT_W-1:0] s);
    return BIT_W'(32'(s));
  endfunction

endpackage

### rtl/buddy_block_allocator.sv
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over 2^(NUM_ORDERS-1) base blocks, free bitmap in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid/in_ready with func, order and address; one
//   result (status, block_address) leaves on out_valid/out_ready per request.
//   cfg_we/cfg_data write region_base while the block is idle.
//   The free bitmap sits in a 64-bit wide RAM with one read and one write per
//   cycle; a small sequencer walks it through a read state and a check or
//   update state for each word or bit touched. Allocate: the order counters
//   are searched upward from the requested order, the words of the first
//   non-empty order are scanned, and the found block is split down. Free:
//   the block and its ancestors up to the top order are tested, descendant
//   ranges are scanned, buddies are tested for merging, and the final block
//   is marked. One item is in flight at a time; in_ready is high only idle.
//   After reset a pass clears all WORDS (128) words of the RAM with the
//   single top-order block marked free; in_ready stays low during the pass.
//   A finished result waits in the output register; while the receiver
//   stalls the next request may still be accepted and processed, and its
//   result holds until the previous transfer completes.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              func,
  input  logic [3:0]        order,
  input  logic [ADDR_W-1:0] address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic [ADDR_W-1:0] block_address,
  input  logic              cfg_we,
  input  logic [ADDR_W-1:0] cfg_data
);

  localparam logic [K_W-1:0] TOP_K = K_W'(TOP_ORDER);

  logic [WORD_W-1:0] mem [WORDS];
  logic [WORD_W-1:0] rdata;
  logic              mem_re;
  logic [WADDR_W-1:0] raddr;
  logic              we;
  logic [WADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata;

  state_t state, state_next;
  phase_t phase, phase_next;
  bitop_t bop, bop_next;

  logic [ADDR_W-1:0] region_base;
  logic              op_func;
  logic [3:0]        op_order;
  logic [ADDR_W-1:0] op_addr;
  logic [K_W-1:0]    cur_k, cur_k_next;
  logic [I_W-1:0]    cur_i, cur_i_next;
  logic [K_W-1:0]    anc_a, anc_a_next;
  logic [I_W-1:0]    anc_i, anc_i_next;
  logic [K_W-1:0]    desc_d, desc_d_next;
  logic [SLOT_W-1:0] scan_lo, scan_lo_next;
  logic [SLOT_W-1:0] scan_hi, scan_hi_next;
  logic [WADDR_W-1:0] scan_w, scan_w_next;
  logic [SLOT_W-1:0] bslot, bslot_next;
  logic [K_W-1:0]    bk, bk_next;
  logic [CNT_W-1:0]  cnt [NUM_ORDERS];
  logic [CNT_W-1:0]  cnt_next [NUM_ORDERS];
  logic [1:0]        res_status, res_status_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  logic              out_valid_next;
  logic [1:0]        out_status_next;
  logic [ADDR_W-1:0] out_addr_next;
  logic [WADDR_W-1:0] clr_ptr;

  // scan and bit helpers
  logic [K_W-1:0]    op_k;
  logic [WADDR_W-1:0] lo_word, hi_word;
  logic [WORD_W-1:0] lo_mask, hi_mask, hits;
  logic              hit_any;
  logic [BIT_W-1:0]  hit_pos;
  logic [SLOT_W-1:0] hit_slot;
  logic              cur_bit;
  logic [K_W-1:0]    desc_tgt;
  logic [SLOT_W-1:0] dlo, dhi, alo, ahi;
  logic [ADDR_W-1:0] off;
  logic [BLK_W-1:0]  blk;
  logic              free_bad;
  logic [I_W-1:0]    free_i;

  assign op_k    = K_W'(op_order);
  assign lo_word = word_of(scan_lo);
  assign hi_word = word_of(scan_hi);
  assign lo_mask = (scan_w == lo_word) ? ({WORD_W{1'b1}} << bit_of(scan_lo))
                                       : {WORD_W{1'b1}};
  assign hi_mask = (scan_w == hi_word)
                 ? ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - bit_of(scan_hi)))
                 : {WORD_W{1'b1}};
  assign hits    = rdata & lo_mask & hi_mask;
  assign hit_any = |hits;

  always_comb begin
    hit_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hits[b]) begin
        hit_pos = BIT_W'(b);
      end
    end
  end

  assign hit_slot = SLOT_W'((32'(scan_w) << BIT_W) | 32'(hit_pos));
  assign cur_bit  = rdata[bit_of(bslot)];

  // descendant range of the block being freed at order desc_tgt
  assign desc_tgt = (state == S_BIT_DO) ? '0 : K_W'(desc_d + 1'b1);
  assign dlo = slot_of(desc_tgt, I_W'(cur_i << (op_k - desc_tgt)));
  assign dhi = SLOT_W'(32'(dlo) + (32'd1 << (op_k - desc_tgt)) - 32'd1);
  assign alo = slot_of(cur_k, '0);
  assign ahi = SLOT_W'(32'(alo) + (32'd1 << (32'(TOP_ORDER) - 32'(cur_k))) - 32'd1);

  assign off      = op_addr - region_base;
  assign blk      = off[ADDR_W-1:BLOCK_SHIFT];
  assign free_bad = (|off[BLOCK_SHIFT-1:0])
                 || ((blk >> TOP_ORDER) != '0)
                 || ((blk & ((BLK_W'(1) << op_order) - BLK_W'(1))) != '0);
  assign free_i   = I_W'(blk >> op_order);

  // next state and datapath
  always_comb begin
    state_next      = state;
    phase_next      = phase;
    bop_next        = bop;
    cur_k_next      = cur_k;
    cur_i_next      = cur_i;
    anc_a_next      = anc_a;
    anc_i_next      = anc_i;
    desc_d_next     = desc_d;
    scan_lo_next    = scan_lo;
    scan_hi_next    = scan_hi;
    scan_w_next     = scan_w;
    bslot_next      = bslot;
    bk_next         = bk;
    cnt_next        = cnt;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    out_valid_next  = out_valid && !out_ready;
    out_status_next = status;
    out_addr_next   = block_address;

    unique case (state)
      S_CLEAR: begin
        if (clr_ptr == WADDR_W'(WORDS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = ST_OK;
          res_addr_next   = '0;
          state_next      = S_DECODE;
        end
      end
      S_DECODE: begin
        if (32'(op_order) >= NUM_ORDERS) begin
          res_status_next = ST_BAD_ORDER;
          state_next      = S_DONE;
        end else if (op_func == FUNC_ALLOC) begin
          cur_k_next = op_k;
          state_next = S_AFIND;
        end else if (free_bad) begin
          res_status_next = ST_BAD_FREE;
          state_next      = S_DONE;
        end else begin
          cur_i_next = free_i;
          cur_k_next = op_k;
          anc_a_next = op_k;
          anc_i_next = free_i;
          bslot_next = slot_of(op_k, free_i);
          bop_next   = B_TEST;
          phase_next = P_FREE_UP;
          state_next = S_BIT_RD;
        end
      end
      S_AFIND: begin
        if (cnt[cur_k] != '0) begin
          scan_lo_next = alo;
          scan_hi_next = ahi;
          scan_w_next  = word_of(alo);
          phase_next   = P_ALLOC_SCAN;
          state_next   = S_SCAN_RD;
        end else if (cur_k == TOP_K) begin
          res_status_next = ST_NO_BLOCK;
          state_next      = S_DONE;
        end else begin
          cur_k_next = cur_k + 1'b1;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (hit_any) begin
          if (phase == P_ALLOC_SCAN) begin
            cur_i_next = I_W'(hit_slot - alo);
            bslot_next = hit_slot;
            bop_next   = B_CLR;
            bk_next    = cur_k;
            phase_next = P_ALLOC_SPLIT;
            state_next = S_BIT_RD;
          end else begin
            res_status_next = ST_BAD_FREE;
            state_next      = S_DONE;
          end
        end else if (scan_w == hi_word) begin
          if (phase == P_ALLOC_SCAN) begin
            res_status_next = ST_NO_BLOCK;
            state_next      = S_DONE;
          end else if (K_W'(desc_d + 1'b1) == op_k) begin
            state_next = S_MERGE;
          end else begin
            desc_d_next  = desc_tgt;
            scan_lo_next = dlo;
            scan_hi_next = dhi;
            scan_w_next  = word_of(dlo);
            state_next   = S_SCAN_RD;
          end
        end else begin
          scan_w_next = scan_w + 1'b1;
          state_next  = S_SCAN_RD;
        end
      end
      S_BIT_RD: begin
        state_next = S_BIT_DO;
      end
      S_BIT_DO: begin
        if (bop == B_SET && !cur_bit) begin
          cnt_next[bk] = cnt[bk] + CNT_W'(1);
        end else if (bop == B_CLR && cur_bit) begin
          cnt_next[bk] = cnt[bk] - CNT_W'(1);
        end
        case (phase)
          P_ALLOC_SPLIT: begin
            if (cur_k > op_k) begin
              cur_k_next = cur_k - 1'b1;
              cur_i_next = I_W'(cur_i << 1);
              bslot_next = slot_of(K_W'(cur_k - 1'b1), I_W'(cur_i << 1) | I_W'(1));
              bop_next   = B_SET;
              bk_next    = K_W'(cur_k - 1'b1);
              state_next = S_BIT_RD;
            end else begin
              res_addr_next = region_base
                            + (ADDR_W'(cur_i) << (32'(op_order) + BLOCK_SHIFT));
              state_next    = S_DONE;
            end
          end
          P_FREE_UP: begin
            if (cur_bit) begin
              res_status_next = ST_BAD_FREE;
              state_next      = S_DONE;
            end else if (anc_a == TOP_K) begin
              if (op_k == '0) begin
                state_next = S_MERGE;
              end else begin
                desc_d_next  = '0;
                scan_lo_next = dlo;
                scan_hi_next = dhi;
                scan_w_next  = word_of(dlo);
                phase_next   = P_FREE_DOWN;
                state_next   = S_SCAN_RD;
              end
            end else begin
              anc_a_next = anc_a + 1'b1;
              anc_i_next = anc_i >> 1;
              bslot_next = slot_of(K_W'(anc_a + 1'b1), anc_i >> 1);
              state_next = S_BIT_RD;
            end
          end
          P_FREE_MERGE: begin
            if (cur_bit) begin
              // buddy is free: take it out and climb one order
              cnt_next[cur_k] = cnt[cur_k] - CNT_W'(1);
              cur_i_next      = cur_i >> 1;
              cur_k_next      = cur_k + 1'b1;
              state_next      = S_MERGE;
            end else begin
              bslot_next = slot_of(cur_k, cur_i);
              bop_next   = B_SET;
              bk_next    = cur_k;
              phase_next = P_FREE_SET;
              state_next = S_BIT_RD;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_MERGE: begin
        if (cur_k == TOP_K) begin
          bslot_next = slot_of(cur_k, cur_i);
          bop_next   = B_SET;
          bk_next    = cur_k;
          phase_next = P_FREE_SET;
        end else begin
          bslot_next = slot_of(cur_k, cur_i ^ I_W'(1));
          bop_next   = B_TEST;
          phase_next = P_FREE_MERGE;
        end
        state_next = S_BIT_RD;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_addr_next   = res_addr;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs and RAM controls
  always_comb begin
    in_ready = (state == S_IDLE);
    mem_re   = 1'b0;
    raddr    = '0;
    we       = 1'b0;
    waddr    = '0;
    wdata    = rdata;
    unique case (state)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_ptr;
        wdata = (clr_ptr == '0) ? WORD_W'(1) : '0;
      end
      S_SCAN_RD: begin
        mem_re = 1'b1;
        raddr  = scan_w;
      end
      S_BIT_RD: begin
        mem_re = 1'b1;
        raddr  = word_of(bslot);
      end
      S_BIT_DO: begin
        we    = (bop != B_TEST) || (phase == P_FREE_MERGE && cur_bit);
        waddr = word_of(bslot);
        wdata[bit_of(bslot)] = (bop == B_SET);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_ptr     <= '0;
      out_valid   <= 1'b0;
      region_base <= '0;
      for (int k = 0; k < NUM_ORDERS; k++) begin
        cnt[k] <= (k == TOP_ORDER) ? CNT_W'(1) : '0;
      end
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      cnt       <= cnt_next;
      if (state == S_CLEAR) begin
        clr_ptr <= clr_ptr + 1'b1;
      end
      if (cfg_we) begin
        region_base <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    phase         <= phase_next;
    bop           <= bop_next;
    cur_k         <= cur_k_next;
    cur_i         <= cur_i_next;
    anc_a         <= anc_a_next;
    anc_i         <= anc_i_next;
    desc_d        <= desc_d_next;
    scan_lo       <= scan_lo_next;
    scan_hi       <= scan_hi_next;
    scan_w        <= scan_w_next;
    bslot         <= bslot_next;
    bk            <= bk_next;
    res_status    <= res_status_next;
    res_addr      <= res_addr_next;
    status        <= out_status_next;
    block_address <= out_addr_next;
    if (in_valid && in_ready) begin
      op_func  <= func;
      op_order <= order;
      op_addr  <= address;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a request but stayed ready");

  a_addr_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (block_address == '0))
    else $error("failed request returned a nonzero address");

  a_top_count: assert property (@(posedge clk) disable iff (rst)
    cnt[TOP_ORDER] <= CNT_W'(1))
    else $error("more than one free top-order block");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result raised outside completion");

endmodule

### tb/sv/tb_buddy_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buddy block allocator testbench
// Directed alloc/free table, then random phases at several region bases; each
// result is checked against its typed row or an in-bench bitmap predictor.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;
  import bba_pkg::*;

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  RAND_ITEMS  = 650;
  localparam int  PHASES      = 5;
  localparam int  DRAIN_WAIT  = 600;
  localparam int  LONG_HOLD   = 600;
  localparam int  REGION_BLKS = 1 << TOP_ORDER;
  localparam logic [ADDR_W-1:0] ALL_ONES = {ADDR_W{1'b1}};
  localparam logic [ADDR_W-1:0] BLK_MASK = {{(ADDR_W-BLOCK_SHIFT){1'b1}},
                                            {BLOCK_SHIFT{1'b0}}};

  typedef struct {
    status_t           st;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  typedef struct {
    logic              fn;
    logic [3:0]        ord;
    logic [ADDR_W-1:0] addr;
    bit                typed;
    status_t           st;
    logic [ADDR_W-1:0] res;
  } req_row_t;

  typedef struct {
    int ord;
    int blk;
  } held_block_t;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic              func;
  logic [3:0]        order;
  logic [ADDR_W-1:0] address;
  logic              out_valid;
  logic              out_ready;
  logic [1:0]        status;
  logic [ADDR_W-1:0] block_address;
  logic              cfg_we;
  logic [ADDR_W-1:0] cfg_data;

  buddy_block_allocator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .order(order), .address(address),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .block_address(block_address),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // predictor state
  bit                free_bits [MAP_SLOTS];
  int                free_per_order [NUM_ORDERS];
  logic [ADDR_W-1:0] region_base;

  alloc_result_t pending_results[$];
  req_row_t      req_table[$];
  held_block_t   held_blocks[$];
  int            fail_count;
  int            cycle_count;
  bit            idle_enable;
  bit            long_hold_req;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int slot_at(int k, longint i);
    return int'(((longint'(1) << (TOP_ORDER - k)) - 1 + i) & (MAP_SLOTS - 1));
  endfunction

  function automatic void set_free(int k, longint i, bit f);
    int s;
    s = slot_at(k, i);
    if (f && !free_bits[s]) begin
      free_bits[s] = 1'b1;
      free_per_order[k]++;
    end else if (!f && free_bits[s]) begin
      free_bits[s] = 1'b0;
      free_per_order[k]--;
    end
  endfunction

  function automatic void reset_map();
    foreach (free_bits[s]) free_bits[s] = 1'b0;
    foreach (free_per_order[k]) free_per_order[k] = 0;
    set_free(TOP_ORDER, 0, 1'b1);
    region_base = '0;
  endfunction

  function automatic bit covered_by_free(int k, longint i);
    for (int a = k; a <= TOP_ORDER; a++)
      if (free_bits[slot_at(a, i >> (a - k))]) return 1'b1;
    for (int d = 0; d < k; d++)
      for (longint j = 0; j < (longint'(1) << (k - d)); j++)
        if (free_bits[slot_at(d, (i << (k - d)) + j)]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic alloc_result_t predict_request(logic fn, logic [3:0] ord,
                                                   logic [ADDR_W-1:0] addr);
    alloc_result_t     r;
    logic [ADDR_W-1:0] off;
    longint            blk;
    longint            i;
    int                j;
    bit                found;
    r.st   = ST_OK;
    r.addr = '0;
    found  = 1'b0;
    i      = 0;
    if (ord >= NUM_ORDERS) begin
      r.st = ST_BAD_ORDER;
    end else if (fn == FUNC_ALLOC) begin
      for (j = ord; j <= TOP_ORDER; j++) begin
        if (free_per_order[j] != 0) begin
          for (i = 0; i < (longint'(1) << (TOP_ORDER - j)); i++)
            if (free_bits[slot_at(j, i)]) begin
              found = 1'b1;
              break;
            end
        end
        if (found) break;
      end
      if (!found) begin
        r.st = ST_NO_BLOCK;
      end else begin
        set_free(j, i, 1'b0);
        while (j > ord) begin
          j--;
          i = i << 1;
          set_free(j, i + 1, 1'b1);
        end
        r.addr = region_base + ADDR_W'((i << ord) << BLOCK_SHIFT);
      end
    end else begin
      off = addr - region_base;
      blk = longint'(off >> BLOCK_SHIFT);
      if (off[BLOCK_SHIFT-1:0] != 0 || blk >= REGION_BLKS ||
          (blk & ((longint'(1) << ord) - 1)) != 0) begin
        r.st = ST_BAD_FREE;
      end else begin
        i = blk >> ord;
        if (covered_by_free(ord, i)) begin
          r.st = ST_BAD_FREE;
        end else begin
          j = ord;
          // merge upward while the buddy is free
          while (j < TOP_ORDER && free_bits[slot_at(j, i ^ 1)]) begin
            set_free(j, i ^ 1, 1'b0);
            i = i >> 1;
            j++;
          end
          set_free(j, i, 1'b1);
        end
      end
    end
    return r;
  endfunction

  function automatic void add_row(logic fn, logic [3:0] ord, logic [ADDR_W-1:0] addr,
                                  bit typed, status_t st, logic [ADDR_W-1:0] res);
    req_row_t row;
    row.fn = fn; row.ord = ord; row.addr = addr;
    row.typed = typed; row.st = st; row.res = res;
    req_table.push_back(row);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {8'($urandom_range(0, 255)), 32'($urandom())};
  endfunction

  task automatic transfer_request(logic fn, logic [3:0] ord, logic [ADDR_W-1:0] addr,
                                  bit typed, status_t st, logic [ADDR_W-1:0] res);
    int            gap;
    alloc_result_t r;
    gap = idle_enable ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    func     = fn;
    order    = ord;
    address  = addr;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_request(fn, ord, addr);
    if (fn == FUNC_ALLOC && r.st == ST_OK)
      held_blocks.push_back('{int'(ord), int'((r.addr - region_base) >> BLOCK_SHIFT)});
    if (typed) begin
      r.st   = st;
      r.addr = res;
    end
    pending_results.push_back(r);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_region_base(logic [ADDR_W-1:0] v);
    cfg_data = v;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we   = 1'b0;
    region_base = v;
  endtask

  task automatic random_request();
    int          kind;
    int          pick;
    held_block_t hb;
    logic [3:0]  ord;
    kind = $urandom_range(0, 99);
    if (kind < 45) begin
      ord = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(0, 5)) : 4'($urandom_range(0, 15));
      transfer_request(FUNC_ALLOC, ord, rand_addr(), 1'b0, ST_OK, '0);
    end else if (kind < 85 && held_blocks.size() != 0) begin
      pick = $urandom_range(0, held_blocks.size() - 1);
      hb   = held_blocks[pick];
      held_blocks.delete(pick);
      transfer_request(FUNC_FREE, 4'(hb.ord),
                       region_base + ADDR_W'(longint'(hb.blk) << BLOCK_SHIFT),
                       1'b0, ST_OK, '0);
    end else begin
      // noise: wild addresses, misaligned or double frees, bad orders
      ord = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 1))
        transfer_request(FUNC_FREE, ord, rand_addr(), 1'b0, ST_OK, '0);
      else
        transfer_request(FUNC_FREE, ord,
                         region_base + ADDR_W'(longint'($urandom_range(0, REGION_BLKS - 1))
                                               << BLOCK_SHIFT),
                         1'b0, ST_OK, '0);
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        stall = idle_enable ? $urandom_range(0, 14) : 0;
        if (stall > 0) begin
          out_ready = 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status=%0d block_address=%h",
               status, block_address);
        fail_count++;
      end else begin
        alloc_result_t e;
        e = pending_results.pop_front();
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status);
          fail_count++;
        end
        if (block_address !== e.addr) begin
          $error("block_address: expected %h, got %h", e.addr, block_address);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_buddy_block_allocator failed");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] bases [PHASES];
    rst = 1'b1;
    in_valid = 1'b0;
    func = FUNC_ALLOC;
    order = '0;
    address = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    fail_count = 0;
    cycle_count = 0;
    idle_enable = 1'b1;
    long_hold_req = 1'b0;
    reset_map();
    repeat (4) @(negedge clk);
    rst = 1'b0;

    add_row(FUNC_ALLOC, 4'd13, '0, 1'b1, ST_BAD_ORDER, '0);
    add_row(FUNC_ALLOC, 4'd15, '0, 1'b1, ST_BAD_ORDER, '0);
    add_row(FUNC_FREE,  4'd14, '0, 1'b1, ST_BAD_ORDER, '0);
    add_row(FUNC_ALLOC, 4'd12, ALL_ONES, 1'b1, ST_OK, '0);
    add_row(FUNC_ALLOC, 4'd0, '0, 1'b1, ST_NO_BLOCK, '0);
    add_row(FUNC_FREE,  4'd12, '0, 1'b1, ST_OK, '0);
    add_row(FUNC_FREE,  4'd12, '0, 1'b1, ST_BAD_FREE, '0);
    add_row(FUNC_FREE,  4'd0, 40'h1, 1'b1, ST_BAD_FREE, '0);
    add_row(FUNC_FREE,  4'd0, 40'h100_0000, 1'b1, ST_BAD_FREE, '0);
    add_row(FUNC_FREE,  4'd0, ALL_ONES, 1'b1, ST_BAD_FREE, '0);
    add_row(FUNC_ALLOC, 4'd0, '0, 1'b1, ST_OK, '0);
    add_row(FUNC_ALLOC, 4'd0, '0, 1'b0, ST_OK, '0);
    add_row(FUNC_ALLOC, 4'd3, '0, 1'b0, ST_OK, '0);
    add_row(FUNC_FREE,  4'd1, 40'h2000, 1'b0, ST_OK, '0);
    add_row(FUNC_FREE,  4'd0, 40'h1000, 1'b0, ST_OK, '0);
    add_row(FUNC_FREE,  4'd0, 40'h1000, 1'b0, ST_OK, '0);
    add_row(FUNC_FREE,  4'd2, 40'h6000, 1'b0, ST_OK, '0);
    add_row(FUNC_ALLOC, 4'd12, '0, 1'b0, ST_OK, '0);
    add_row(FUNC_ALLOC, 4'd11, '0, 1'b0, ST_OK, '0);
    add_row(FUNC_ALLOC, 4'd11, '0, 1'b0, ST_OK, '0);
    add_row(FUNC_FREE,  4'd0, '0, 1'b0, ST_OK, '0);
    add_row(FUNC_FREE,  4'd3, 40'h8000, 1'b0, ST_OK, '0);
    foreach (req_table[n])
      transfer_request(req_table[n].fn, req_table[n].ord, req_table[n].addr,
                       req_table[n].typed, req_table[n].st, req_table[n].res);
    drain_results();

    bases[0] = ALL_ONES;
    bases[1] = '0;
    bases[2] = rand_addr();
    bases[3] = rand_addr() & BLK_MASK;
    bases[4] = ALL_ONES - 40'hFFF;
    for (int p = 0; p < PHASES; p++) begin
      write_region_base(bases[p]);
      idle_enable = (p != 1);
      if (p == 2) long_hold_req = 1'b1;
      repeat (RAND_ITEMS / PHASES) random_request();
      drain_results();
    end

    if (fail_count == 0) begin
      $display("tb_buddy_block_allocator passed");
    end else begin
      $display("tb_buddy_block_allocator failed");
    end
    $finish;
  end

endmodule
